// File: rtl/bfpus_pkg.sv
// Package for the bit-field pack/unpack store unit.
// Holds store geometry, operation codes and field widths.
// No dependencies.
package bfpus_pkg;

  // Store geometry
  localparam int STORE_BYTES = 256;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int TOTAL_BITS  = STORE_BYTES * 8;

  // Field widths
  localparam int POS_W   = 11;
  localparam int WID_W   = 4;
  localparam int VAL_W   = 8;
  localparam int NPOS_W  = 12;
  localparam int IN_DW   = 24;
  localparam int OUT_DW  = 24;

  localparam logic [7:0] BYTE_MASK = 8'hff;
  localparam logic [WID_W-1:0] MAX_WIDTH = WID_W'(8);

  // Operation codes
  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_EXTRACT = 1'b1
  } func_t;

endpackage

// File: rtl/bit_field_pack_unpack_store_unit.sv
// Top level of the bit-field pack/unpack store unit: MSB-first bit stream
// in a byte store, field insert and extract of 1 to 8 bits.
// Depends on bfpus_pkg.
//
//  Channel | Dir | tdata (low bit up)                          | tuser
//  in_     | in  | bit_offset[10:0] field_width[14:11]           | func
//          |     | field_value[22:15], zero fill [23]            |
//  out_    | out | read_value[7:0] next_position[19:8], fill     | range_error
//
// An in-range extract runs through calc and done; an insert writes one byte in
// calc and, if the field spans two, the second in a write step through the single
// write port; width zero and range errors skip to done. One transaction is in work
// at a time; in_tready is low while it runs. A result waiting in the output register
// holds the sequencer in its last step until taken. Synchronous reset clears
// per-byte valid bits, so the store reads as zero at once, with no clearing pass.
module bit_field_pack_unpack_store_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // bit_offset[10:0], field_width[14:11], field_value[22:15]
  input  logic [bfpus_pkg::IN_DW-1:0] in_tdata,
  // func
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // read_value[7:0], next_position[19:8]
  output logic [bfpus_pkg::OUT_DW-1:0] out_tdata,
  // range_error
  output logic                        out_tuser
);
  import bfpus_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WR1,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Working registers for the current transaction
  logic              func_r, func_nxt;
  logic [2:0]        off_r, off_nxt;
  logic [WID_W-1:0]  w_r, w_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              spans_r, spans_nxt;
  logic [7:0]        lo_r, lo_nxt;
  logic [7:0]        res_rd_r, res_rd_nxt;
  logic [NPOS_W-1:0] res_pos_r, res_pos_nxt;
  logic              res_err_r, res_err_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_rd_r, out_rd_nxt;
  logic [NPOS_W-1:0] out_pos_r, out_pos_nxt;
  logic              out_err_r, out_err_nxt;

  // Store and its per-byte valid bits
  logic [7:0]        mem [STORE_BYTES];
  logic [STORE_BYTES-1:0] vld_r;
  logic [7:0]        q0_r, q1_r;
  logic              qv0_r, qv1_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;

  // Input field decode
  logic [POS_W-1:0]  in_pos;
  logic [WID_W-1:0]  in_w_raw, in_w;
  logic [VAL_W-1:0]  in_val;
  logic [NPOS_W-1:0] in_end;
  logic              in_err, in_skip, in_spans;

  // Shared shift / merge unit
  logic [15:0]       win, win_sh, mask16, ins16, new_win;
  logic [8:0]        fmask9;
  logic [7:0]        fmask;
  logic [4:0]        shamt;
  logic [7:0]        b0, b1;
  logic              accept, out_free;

  assign in_pos   = in_tdata[10:0];
  assign in_w_raw = in_tdata[14:11];
  assign in_val   = in_tdata[22:15];
  assign in_w     = (in_w_raw > MAX_WIDTH) ? MAX_WIDTH : in_w_raw;
  assign in_end   = NPOS_W'(in_pos) + NPOS_W'(in_w);
  assign in_err   = (in_w != '0) && (32'(in_end) > 32'(TOTAL_BITS));
  assign in_skip  = (in_w == '0) || in_err;
  assign in_spans = (4'({1'b0, in_pos[2:0]}) + in_w) > 4'd8;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW - 8 - NPOS_W){1'b0}}, out_pos_r, out_rd_r};
  assign out_tuser  = out_err_r;

  // Window of the one or two addressed bytes; unwritten bytes read as zero
  assign b0     = qv0_r ? q0_r : 8'd0;
  assign b1     = (spans_r && qv1_r) ? q1_r : 8'd0;
  assign win    = {b0, b1};
  assign shamt  = 5'd16 - 5'(off_r) - 5'(w_r);
  assign fmask9 = (9'd1 << w_r) - 9'd1;
  assign fmask  = fmask9[7:0];
  assign win_sh = win >> shamt;
  assign mask16 = {8'd0, fmask} << shamt;
  assign ins16  = {8'd0, val_r & fmask} << shamt;
  assign new_win = (win & ~mask16) | ins16;

  // Sequencer next-state and datapath control
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    off_nxt       = off_r;
    w_nxt         = w_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    spans_nxt     = spans_r;
    lo_nxt        = lo_r;
    res_rd_nxt    = res_rd_r;
    res_pos_nxt   = res_pos_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_pos_nxt   = out_pos_r;
    out_err_nxt   = out_err_r;
    rd_en         = 1'b0;
    rd_addr       = ADDR_W'(in_pos[POS_W-1:3]);
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = new_win[15:8];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt    = in_tuser;
          off_nxt     = in_pos[2:0];
          w_nxt       = in_w;
          val_nxt     = in_val;
          idx_nxt     = ADDR_W'(in_pos[POS_W-1:3]);
          spans_nxt   = in_spans;
          res_rd_nxt  = 8'd0;
          res_err_nxt = in_err;
          res_pos_nxt = in_skip ? NPOS_W'(in_pos) : in_end;
          if (in_skip) begin
            state_nxt = ST_DONE;
          end else begin
            rd_en     = 1'b1;
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (func_r == FUNC_EXTRACT) begin
          res_rd_nxt = win_sh[7:0] & fmask;
          state_nxt  = ST_DONE;
        end else begin
          we     = 1'b1;
          lo_nxt = new_win[7:0] & BYTE_MASK;
          state_nxt = spans_r ? ST_WR1 : ST_DONE;
        end
      end
      ST_WR1: begin
        we        = 1'b1;
        waddr     = idx_r + ADDR_W'(1);
        wdata     = lo_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = res_rd_r;
          out_pos_nxt   = res_pos_r;
          out_err_nxt   = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
    func_r    <= func_nxt;
    off_r     <= off_nxt;
    w_r       <= w_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    spans_r   <= spans_nxt;
    lo_r      <= lo_nxt;
    res_rd_r  <= res_rd_nxt;
    res_pos_r <= res_pos_nxt;
    res_err_r <= res_err_nxt;
    out_rd_r  <= out_rd_nxt;
    out_pos_r <= out_pos_nxt;
    out_err_r <= out_err_nxt;
  end

  // Byte store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      q0_r  <= mem[rd_addr];
      q1_r  <= mem[rd_addr + ADDR_W'(1)];
      qv0_r <= vld_r[rd_addr];
      qv1_r <= vld_r[rd_addr + ADDR_W'(1)];
    end
  end

endmodule
